### src/iq_pair_dc_block_gain_defines.svh
// ----------------------------------------------------------------------------
// IQ pair DC block assertion macros
// Shared property forms for the concurrent checks of the block.
// ----------------------------------------------------------------------------
`ifndef IQ_PAIR_DC_BLOCK_GAIN_DEFINES_SVH
`define IQ_PAIR_DC_BLOCK_GAIN_DEFINES_SVH

// same-cycle implication, disabled during reset
`define IQDC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("iqdc same-cycle check failed");

// next-cycle implication, disabled during reset
`define IQDC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("iqdc next-cycle check failed");

`endif

### src/iqdc_pkg.sv
// ----------------------------------------------------------------------------
// IQ pair DC block package
// Register codes, reset values, saturation limits and shared types.
// ----------------------------------------------------------------------------
`default_nettype none

package iqdc_pkg;

	localparam int CHAN_W    = 4;
	localparam int CFG_W     = 4;
	localparam int CFG_IDX_W = 2;
	localparam int OUT_W     = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DC_SHIFT   = 2'd0,
		REG_GAIN_SHIFT = 2'd1,
		REG_I_CHANNEL  = 2'd2,
		REG_Q_CHANNEL  = 2'd3
	} cfg_reg_t;

	localparam logic [CFG_W-1:0] DC_SHIFT_RST   = 4'd8;
	localparam logic [CFG_W-1:0] GAIN_SHIFT_RST = 4'd4;
	localparam logic [CFG_W-1:0] I_CHANNEL_RST  = 4'd5;
	localparam logic [CFG_W-1:0] Q_CHANNEL_RST  = 4'd6;

	localparam logic signed [OUT_W-1:0] SAT_MAX = 16'sh7fff;
	localparam logic signed [OUT_W-1:0] SAT_MIN = 16'sh8000;

	typedef struct packed {
		logic [CFG_W-1:0] dc_shift;
		logic [CFG_W-1:0] gain_shift;
	} shift_cfg_t;

endpackage

`default_nettype wire

### src/iqdc_lane.sv
// ----------------------------------------------------------------------------
// IQ pair DC block lane
// Leaky-integrator DC estimate, DC removal, gain shift and saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module iqdc_lane
	import iqdc_pkg::*;
#(
	parameter int SAMPLE_BITS = 12
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          update,
	input  wire logic signed [SAMPLE_BITS-1:0] x,
	input  wire shift_cfg_t                    shift_cfg,
	output logic signed [OUT_W-1:0]            y
);

	localparam int DW = SAMPLE_BITS + 8;
	localparam int YW = SAMPLE_BITS + 16;

	logic signed [DW-1:0]          dc_q;
	logic signed [DW-1:0]          dc_next;
	logic signed [DW-1:0]          x_q8;
	logic signed [DW:0]            diff;
	logic signed [DW:0]            step;
	logic signed [DW:0]            sum;
	logic signed [SAMPLE_BITS-1:0] dc_int;
	logic signed [SAMPLE_BITS:0]   y_raw;
	logic signed [YW-1:0]          y_wide;
	logic signed [YW-1:0]          y_gain;
	logic                          in_range;

	always_comb begin
		x_q8     = $signed({x, 8'b0});
		diff     = $signed({x_q8[DW-1], x_q8}) - $signed({dc_q[DW-1], dc_q});
		step     = diff >>> shift_cfg.dc_shift;
		sum      = $signed({dc_q[DW-1], dc_q}) + step;
		dc_next  = sum[DW-1:0];
		dc_int   = dc_next[DW-1:8];
		y_raw    = $signed({x[SAMPLE_BITS-1], x}) - $signed({dc_int[SAMPLE_BITS-1], dc_int});
		y_wide   = $signed({{(YW-SAMPLE_BITS-1){y_raw[SAMPLE_BITS]}}, y_raw});
		y_gain   = y_wide <<< shift_cfg.gain_shift;
		in_range = (&y_gain[YW-1:OUT_W-1]) | ~(|y_gain[YW-1:OUT_W-1]);
		if (in_range) begin
			y = y_gain[OUT_W-1:0];
		end else if (y_gain[YW-1]) begin
			y = SAT_MIN;
		end else begin
			y = SAT_MAX;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dc_q <= '0;
		end else if (update) begin
			dc_q <= dc_next;
		end
	end

endmodule

`default_nettype wire

### src/iq_pair_dc_block_gain.sv
// ----------------------------------------------------------------------------
// IQ pair DC block with gain
// Pairs I and Q conversion words, removes DC per channel and applies gain.
// ----------------------------------------------------------------------------
// The block takes one conversion word per clock cycle unless a completed
// pair is held in the input register waiting for the result register. A
// transferred word lands in the input register; in the next cycle it is
// classified against the I and Q channel numbers, and a Q word that
// completes a pair updates both Q8 DC integrators and loads the result
// register, which drives the master side, once that register is free.
// While a result waits in the result register, I words and unpaired words
// keep flowing; a further pair waits in the input register for the result
// register to drain, holding back the words behind it. Configuration writes
// take effect at the edge where cfg_we is high and are meant for idle
// periods.
// ----------------------------------------------------------------------------
`default_nettype none

module iq_pair_dc_block_gain
	import iqdc_pkg::*;
#(
	parameter int SAMPLE_BITS = 12
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   cfg_we,
	input  wire logic [CFG_IDX_W-1:0]                   cfg_index,
	input  wire logic [CFG_W-1:0]                       cfg_data,
	input  wire logic                                   s_tvalid,
	output logic                                        s_tready,
	// sample
	input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]       s_tdata,
	// channel
	input  wire logic [CHAN_W-1:0]                      s_tuser,
	output logic                                        m_tvalid,
	input  wire logic                                   m_tready,
	// q_out in the upper half, i_out in the lower half
	output logic [2*OUT_W-1:0]                          m_tdata
);

	`include "iq_pair_dc_block_gain_defines.svh"

	logic [CFG_W-1:0]       dc_shift_q;
	logic [CFG_W-1:0]       gain_shift_q;
	logic [CFG_W-1:0]       i_channel_q;
	logic [CFG_W-1:0]       q_channel_q;
	shift_cfg_t             shift_cfg;

	logic                   valid_s1;
	logic [CHAN_W-1:0]      chan_s1;
	logic [SAMPLE_BITS-1:0] samp_s1;
	logic [SAMPLE_BITS-1:0] pending_q;
	logic                   have_pending_q;

	logic                   is_i;
	logic                   is_pair;
	logic                   out_free;
	logic                   s1_adv;
	logic                   pair_fire;
	logic                   in_xfer;

	logic signed [SAMPLE_BITS-1:0] x_i;
	logic signed [SAMPLE_BITS-1:0] x_q;
	logic signed [OUT_W-1:0]       y_i;
	logic signed [OUT_W-1:0]       y_q;

	logic                   m_valid_q;
	logic [OUT_W-1:0]       i_out_q;
	logic [OUT_W-1:0]       q_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dc_shift_q   <= DC_SHIFT_RST;
			gain_shift_q <= GAIN_SHIFT_RST;
			i_channel_q  <= I_CHANNEL_RST;
			q_channel_q  <= Q_CHANNEL_RST;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_DC_SHIFT:   dc_shift_q   <= cfg_data;
				REG_GAIN_SHIFT: gain_shift_q <= cfg_data;
				REG_I_CHANNEL:  i_channel_q  <= cfg_data;
				REG_Q_CHANNEL:  q_channel_q  <= cfg_data;
			endcase
		end
	end

	assign shift_cfg = '{dc_shift: dc_shift_q, gain_shift: gain_shift_q};

	always_comb begin
		is_i      = chan_s1 == i_channel_q;
		is_pair   = !is_i && (chan_s1 == q_channel_q) && have_pending_q;
		out_free  = !m_valid_q || m_tready;
		s1_adv    = valid_s1 && (!is_pair || out_free);
		pair_fire = s1_adv && is_pair;
		s_tready  = !valid_s1 || s1_adv;
		in_xfer   = s_tvalid && s_tready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			chan_s1 <= s_tuser;
			samp_s1 <= s_tdata[SAMPLE_BITS-1:0];
		end
	end

	// hold the latest I word until a Q word consumes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_pending_q <= 1'b0;
		end else if (s1_adv && is_i) begin
			have_pending_q <= 1'b1;
		end else if (pair_fire) begin
			have_pending_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && is_i) begin
			pending_q <= samp_s1;
		end
	end

	// center the codes: flipping the top bit subtracts mid-scale
	assign x_i = $signed({~pending_q[SAMPLE_BITS-1], pending_q[SAMPLE_BITS-2:0]});
	assign x_q = $signed({~samp_s1[SAMPLE_BITS-1], samp_s1[SAMPLE_BITS-2:0]});

	iqdc_lane #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_lane_i (
		.clk       (clk),
		.arst_n    (arst_n),
		.update    (pair_fire),
		.x         (x_i),
		.shift_cfg (shift_cfg),
		.y         (y_i)
	);

	iqdc_lane #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_lane_q (
		.clk       (clk),
		.arst_n    (arst_n),
		.update    (pair_fire),
		.x         (x_q),
		.shift_cfg (shift_cfg),
		.y         (y_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (pair_fire) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pair_fire) begin
			i_out_q <= y_i;
			q_out_q <= y_q;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {q_out_q, i_out_q};

	`IQDC_ASSERT_NXT(a_pair_loads_result, clk, arst_n, pair_fire, m_tvalid)
	`IQDC_ASSERT_NXT(a_pair_clears_pending, clk, arst_n, pair_fire, !have_pending_q)
	`IQDC_ASSERT_NXT(a_i_word_held, clk, arst_n, s1_adv && is_i,
		have_pending_q && (pending_q == $past(samp_s1)))
	`IQDC_ASSERT_IMP(a_no_pair_overwrite, clk, arst_n, m_valid_q && !m_tready, !pair_fire)

endmodule

`default_nettype wire

### test/tb_top.sv
// ----------------------------------------------------------------------------
// IQ pair DC block testbench
// Streams conversion words through the block under a sequence of register
// settings and checks every I/Q pair against a cycle-free model of the
// pairing, the per-lane DC integrators, the gain and the saturation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
	import iqdc_pkg::*;

	localparam int MID_CODE    = 2048;
	localparam int CODE_MAX    = 4095;
	localparam int SETTLE_CYC  = 6;
	localparam int LONG_HOLD   = 400;
	localparam int PHASE_WORDS = 170;

	typedef struct packed {
		logic signed [OUT_W-1:0] q_val;
		logic signed [OUT_W-1:0] i_val;
	} iq_pair_t;

	class iq_dc_tracker;
		logic [CFG_W-1:0]  dc_shift;
		logic [CFG_W-1:0]  gain_shift;
		logic [CHAN_W-1:0] i_chan;
		logic [CHAN_W-1:0] q_chan;
		logic [11:0]       held_i;
		bit                held;
		logic signed [19:0] dc_i;
		logic signed [19:0] dc_q;
		iq_pair_t          pair_queue[$];
		int                errors;
		int                useful_words;

		function new();
			dc_shift     = DC_SHIFT_RST;
			gain_shift   = GAIN_SHIFT_RST;
			i_chan       = I_CHANNEL_RST;
			q_chan       = Q_CHANNEL_RST;
			held_i       = '0;
			held         = 1'b0;
			dc_i         = '0;
			dc_q         = '0;
			errors       = 0;
			useful_words = 0;
		endfunction

		function void set_reg(cfg_reg_t idx, logic [CFG_W-1:0] v);
			case (idx)
				REG_DC_SHIFT:   dc_shift = v;
				REG_GAIN_SHIFT: gain_shift = v;
				REG_I_CHANNEL:  i_chan = v;
				REG_Q_CHANNEL:  q_chan = v;
			endcase
		endfunction

		function logic signed [OUT_W-1:0] remove_dc(input logic [11:0] code,
				inout logic signed [19:0] dc);
			int x;
			int acc;
			int y;
			x   = int'(code) - MID_CODE;
			acc = int'(dc);
			acc = acc + (((x <<< 8) - acc) >>> dc_shift);
			dc  = acc[19:0];
			y   = (x - (acc >>> 8)) <<< gain_shift;
			if (y > SAT_MAX)
				y = SAT_MAX;
			else if (y < SAT_MIN)
				y = SAT_MIN;
			return y[OUT_W-1:0];
		endfunction

		function void take_word(logic [CHAN_W-1:0] ch, logic [15:0] data);
			iq_pair_t p;
			if (ch == i_chan) begin
				held_i = data[11:0];
				held   = 1'b1;
				useful_words++;
			end else if (ch == q_chan && held) begin
				p.i_val = remove_dc(held_i, dc_i);
				p.q_val = remove_dc(data[11:0], dc_q);
				pair_queue.push_back(p);
				held = 1'b0;
				useful_words++;
			end
		endfunction

		function void check_pair(logic [2*OUT_W-1:0] data);
			iq_pair_t got;
			iq_pair_t want;
			got = data;
			if (pair_queue.size() == 0) begin
				$display("%0t: unexpected pair i=%0d q=%0d", $time, got.i_val, got.q_val);
				errors++;
				return;
			end
			want = pair_queue.pop_front();
			if (got.i_val !== want.i_val) begin
				$display("%0t: i_out expected %0d actual %0d", $time, want.i_val, got.i_val);
				errors++;
			end
			if (got.q_val !== want.q_val) begin
				$display("%0t: q_out expected %0d actual %0d", $time, want.q_val, got.q_val);
				errors++;
			end
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [15:0]          s_tdata;
	logic [CHAN_W-1:0]    s_tuser;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [2*OUT_W-1:0]   m_tdata;

	bit tx_calm;
	bit rx_calm;
	bit rx_hold_req;

	iq_dc_tracker tracker = new();

	iq_pair_dc_block_gain DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always #10 clk = ~clk;

	function automatic int pick_gap(bit calm);
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [15:0] pick_code(int centre);
		logic [15:0] data;
		int r;
		int v;
		r = $urandom_range(0, 99);
		if (r < 10) begin
			case ($urandom_range(0, 3))
				0:       v = 0;
				1:       v = CODE_MAX;
				2:       v = MID_CODE - 1;
				default: v = MID_CODE;
			endcase
		end else if (r < 30) begin
			v = $urandom_range(0, CODE_MAX);
		end else begin
			v = centre + $urandom_range(0, 64) - 32;
			if (v < 0)
				v = 0;
			if (v > CODE_MAX)
				v = CODE_MAX;
		end
		data = 16'(v);
		// stray bits above the code width
		if ($urandom_range(0, 9) == 0)
			data[15:12] = 4'($urandom_range(0, 15));
		return data;
	endfunction

	task automatic send_word(input logic [CHAN_W-1:0] ch, input logic [15:0] data);
		int gap;
		gap = pick_gap(tx_calm);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= ch;
		s_tdata  <= data;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		tracker.take_word(ch, data);
	endtask

	task automatic drain_and_settle();
		s_tvalid <= 1'b0;
		while (tracker.pair_queue.size() != 0) @(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic load_regs(input logic [CFG_W-1:0] dcs, input logic [CFG_W-1:0] gs,
			input logic [CFG_W-1:0] ich, input logic [CFG_W-1:0] qch);
		logic [CFG_W-1:0] vals [4];
		vals = '{dcs, gs, ich, qch};
		for (int k = 0; k < 4; k++) begin
			cfg_we    <= 1'b1;
			cfg_index <= cfg_reg_t'(k);
			cfg_data  <= vals[k];
			@(posedge clk);
			tracker.set_reg(cfg_reg_t'(k), vals[k]);
		end
		cfg_we <= 1'b0;
	endtask

	task automatic run_phase(input int goal);
		int start;
		int centre;
		int r;
		logic [CHAN_W-1:0] ich;
		logic [CHAN_W-1:0] qch;
		start  = tracker.useful_words;
		centre = $urandom_range(0, CODE_MAX);
		ich    = tracker.i_chan;
		qch    = tracker.q_chan;
		while (tracker.useful_words - start < goal) begin
			r = $urandom_range(0, 99);
			if (r < 75) begin
				send_word(ich, pick_code(centre));
				send_word(qch, pick_code(centre));
			end else if (r < 83) begin
				send_word(ich, pick_code(centre));
				send_word(ich, pick_code(centre));
				send_word(qch, pick_code(centre));
			end else if (r < 90) begin
				send_word(qch, pick_code(centre));
			end else begin
				send_word(CHAN_W'($urandom_range(0, 15)), pick_code(centre));
			end
		end
		drain_and_settle();
	endtask

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			tracker.check_pair(m_tdata);
	end

	initial begin : rx_side
		int stall_left;
		stall_left = 0;
		m_tready   = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (rx_hold_req) begin
				rx_hold_req = 1'b0;
				stall_left  = LONG_HOLD;
			end
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				stall_left = pick_gap(rx_calm);
			end
		end
	end

	initial begin : stimulus
		int waited;
		arst_n      = 1'b0;
		cfg_we      = 1'b0;
		cfg_index   = REG_DC_SHIFT;
		cfg_data    = '0;
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		s_tuser     = '0;
		tx_calm     = 1'b0;
		rx_calm     = 1'b0;
		rx_hold_req = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset settings: lone Q, other channels, extremes, overwrite, stray bits
		send_word(Q_CHANNEL_RST, 16'd4095);
		send_word(4'd0, 16'd0);
		send_word(4'd15, 16'hffff);
		send_word(I_CHANNEL_RST, 16'd4095);
		send_word(Q_CHANNEL_RST, 16'd0);
		send_word(I_CHANNEL_RST, 16'd0);
		send_word(I_CHANNEL_RST, 16'd4095);
		send_word(Q_CHANNEL_RST, 16'd4095);
		send_word(I_CHANNEL_RST, 16'd2048);
		send_word(Q_CHANNEL_RST, 16'd2048);
		send_word(I_CHANNEL_RST, 16'd2047);
		send_word(Q_CHANNEL_RST, 16'd2047);
		send_word(I_CHANNEL_RST, 16'hf800);
		send_word(Q_CHANNEL_RST, 16'ha000);
		send_word(Q_CHANNEL_RST, 16'd100);
		drain_and_settle();

		// integrator that follows the input, largest gain
		load_regs(4'd0, 4'd15, 4'd0, 4'd15);
		send_word(4'd0, 16'd0);
		send_word(4'd15, 16'd4095);
		send_word(4'd0, 16'd4095);
		send_word(4'd15, 16'd0);
		drain_and_settle();

		// slowest integrator, unity gain
		load_regs(4'd15, 4'd0, 4'd15, 4'd0);
		send_word(4'd15, 16'd4095);
		send_word(4'd0, 16'd0);
		send_word(4'd15, 16'd0);
		send_word(4'd0, 16'd4095);
		drain_and_settle();

		// I and Q on one channel: never pairs
		load_regs(DC_SHIFT_RST, GAIN_SHIFT_RST, 4'd3, 4'd3);
		send_word(4'd3, 16'd1000);
		send_word(4'd3, 16'd3000);
		send_word(4'd4, 16'd500);
		drain_and_settle();

		for (int p = 0; p < 9; p++) begin
			tx_calm = 1'b0;
			rx_calm = 1'b0;
			case (p)
				0: load_regs(DC_SHIFT_RST, GAIN_SHIFT_RST, I_CHANNEL_RST, Q_CHANNEL_RST);
				1: begin
					// hold the output while words keep coming
					load_regs(4'd1, 4'd8, 4'd2, 4'd9);
					tx_calm     = 1'b1;
					rx_hold_req = 1'b1;
				end
				2: load_regs(4'd0, 4'd15, 4'd0, 4'd15);
				3: load_regs(4'd15, 4'd0, 4'd15, 4'd0);
				4: load_regs(4'd4, 4'd2, 4'd7, 4'd7);
				5: begin
					load_regs(4'd6, 4'd3, 4'd10, 4'd12);
					tx_calm = 1'b1;
					rx_calm = 1'b1;
				end
				default: load_regs(CFG_W'($urandom_range(0, 15)),
					CFG_W'($urandom_range(0, 8)),
					CFG_W'($urandom_range(0, 15)),
					CFG_W'($urandom_range(0, 15)));
			endcase
			run_phase(PHASE_WORDS);
		end

		s_tvalid <= 1'b0;
		waited = 0;
		while (tracker.pair_queue.size() != 0 && waited < 2000) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE_CYC) @(posedge clk);
		if (tracker.errors == 0 && tracker.pair_queue.size() == 0) begin
			$display("iq_pair_dc_block_gain test passed");
		end else begin
			if (tracker.pair_queue.size() != 0)
				$display("%0t: %0d expected pairs never arrived", $time,
					tracker.pair_queue.size());
			$display("iq_pair_dc_block_gain test failed");
		end
		$finish;
	end

	initial begin : watchdog
		#(20_000_000);
		$display("%0t: timeout", $time);
		$display("iq_pair_dc_block_gain test failed");
		$finish;
	end

endmodule
